@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the bounded priority queue.
// Define ASSERT_OFF to compile the checks out; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define BPQ_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("bounded_priority_queue: check failed");
`define BPQ_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("bounded_priority_queue: forbidden condition");
`else
`define BPQ_ASSERT(lbl, clk, rstn, prop)
`define BPQ_NEVER(lbl, clk, rstn, cond)
`endif
`endif

@@ sv/bpq_pkg.sv @@
// Types and constants for the bounded priority queue.
// No dependencies; imported by bpq_cell and bounded_priority_queue.
package bpq_pkg;
	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;
	localparam int OUT_CNT_W = 5;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		logic signed [DATA_W-1:0] pri;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic remove;
	} cell_ctl_t;
endpackage

@@ sv/bounded_priority_queue.sv @@
// Bounded priority queue: a chain of DEPTH slots kept sorted by priority,
// highest at the head, equal priorities in arrival order. A request is taken
// every cycle unless a result waits with rsp_stall high; its result appears in
// the cycle after acceptance, from the output register. The rate is set by the
// one priority compare each slot makes per request, all slots in parallel. The
// user must write capacity over cfg channel while queue is idle; not enforced.
module bounded_priority_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bpq_pkg::CAP_W-1:0]     cfg_data,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [1:0]                    opcode,
	input  logic signed [bpq_pkg::DATA_W-1:0] item_value,
	input  logic signed [bpq_pkg::DATA_W-1:0] item_priority,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic signed [bpq_pkg::DATA_W-1:0] head_value,
	output logic signed [bpq_pkg::DATA_W-1:0] head_priority,
	output logic [bpq_pkg::OUT_CNT_W-1:0] entry_count,
	output logic                          is_empty,
	output logic                          is_full,
	output logic                          refused
);
	import bpq_pkg::*;
	`include "assert_macros.svh"

	logic [CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0] count_q, count_d;
	logic             req_fire, full_now, full_next, do_insert, do_remove, is_ins;
	entry_t           item;
	entry_t           cell_q [DEPTH];
	entry_t           cell_d [DEPTH];
	logic [DEPTH-1:0] behind;
	cell_ctl_t        ctl;

	logic                     rsp_valid_q;
	logic signed [DATA_W-1:0] head_value_q, head_priority_q;
	logic [OUT_CNT_W-1:0]     entry_count_q;
	logic                     is_empty_q, is_full_q, refused_q;

	assign cfg_ready = 1'b1;
	assign req_stall = rsp_valid_q && rsp_stall;
	assign req_fire  = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	assign full_now = (CMP_W'(count_q) >= CMP_W'(capacity_q)) || (count_q == CNT_W'(DEPTH));
	assign is_ins    = (opcode == OP_INSERT);
	assign do_insert = req_fire && is_ins && !full_now;
	assign do_remove = req_fire && (opcode == OP_REMOVE) && (count_q != '0);
	assign ctl       = '{insert: do_insert, remove: do_remove};
	assign item      = '{val: item_value, pri: item_priority};

	always_comb begin
		count_d = count_q;
		if (do_insert) begin
			count_d = count_q + 1'b1;
		end else if (do_remove) begin
			count_d = count_q - 1'b1;
		end
	end

	assign full_next = (CMP_W'(count_d) >= CMP_W'(capacity_q)) || (count_d == CNT_W'(DEPTH));

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			if (g == 0) begin : g_head
				bpq_cell u_cell (
					.clk        (clk),
					.ctl        (ctl),
					.item       (item),
					.prev_entry (item),
					.prev_behind(1'b1),
					.next_entry (cell_q[1]),
					.occupied   (count_q > CNT_W'(g)),
					.entry_q    (cell_q[g]),
					.entry_d    (cell_d[g]),
					.behind     (behind[g])
				);
			end else if (g == DEPTH - 1) begin : g_tail
				bpq_cell u_cell (
					.clk        (clk),
					.ctl        (ctl),
					.item       (item),
					.prev_entry (cell_q[g-1]),
					.prev_behind(behind[g-1]),
					.next_entry (cell_q[g]),
					.occupied   (count_q > CNT_W'(g)),
					.entry_q    (cell_q[g]),
					.entry_d    (cell_d[g]),
					.behind     (behind[g])
				);
			end else begin : g_mid
				bpq_cell u_cell (
					.clk        (clk),
					.ctl        (ctl),
					.item       (item),
					.prev_entry (cell_q[g-1]),
					.prev_behind(behind[g-1]),
					.next_entry (cell_q[g+1]),
					.occupied   (count_q > CNT_W'(g)),
					.entry_q    (cell_q[g]),
					.entry_d    (cell_d[g]),
					.behind     (behind[g])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (req_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result payload: state after the request
	always_ff @(posedge clk) begin
		if (req_fire) begin
			head_value_q    <= (count_d == '0) ? '0 : cell_d[0].val;
			head_priority_q <= (count_d == '0) ? '0 : cell_d[0].pri;
			entry_count_q   <= OUT_CNT_W'(count_d);
			is_empty_q      <= (count_d == '0);
			is_full_q       <= full_next;
			refused_q       <= is_ins && full_now;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign head_value    = head_value_q;
	assign head_priority = head_priority_q;
	assign entry_count   = entry_count_q;
	assign is_empty      = is_empty_q;
	assign is_full       = is_full_q;
	assign refused       = refused_q;

	`BPQ_NEVER(a_count_bound, clk, arst_n, count_q > CNT_W'(DEPTH))
	`BPQ_ASSERT(a_refused_full, clk, arst_n, (rsp_valid_q && refused_q) |-> is_full_q)
	`BPQ_ASSERT(a_insert_count, clk, arst_n, do_insert |=> (count_q == $past(count_q) + 1'b1))
	`BPQ_ASSERT(a_head_sorted, clk, arst_n, (count_q >= CNT_W'(2)) |-> ($signed(cell_q[0].pri) >= $signed(cell_q[1].pri)))
endmodule

@@ sv/bpq_cell.sv @@
// One slot of the sorted shift chain: holds an entry, compares it with the
// incoming priority and takes from its neighbours. Depends on bpq_pkg.
module bpq_cell (
	input  logic              clk,
	input  bpq_pkg::cell_ctl_t ctl,
	input  bpq_pkg::entry_t   item,
	input  bpq_pkg::entry_t   prev_entry,
	input  logic              prev_behind,
	input  bpq_pkg::entry_t   next_entry,
	input  logic              occupied,
	output bpq_pkg::entry_t   entry_q,
	output bpq_pkg::entry_t   entry_d,
	output logic              behind
);
	import bpq_pkg::*;

	// new item goes behind every held entry of greater or equal priority
	assign behind = occupied && ($signed(item.pri) <= $signed(entry_q.pri));

	always_comb begin
		entry_d = entry_q;
		if (ctl.insert) begin
			if (behind) begin
				entry_d = entry_q;
			end else if (prev_behind) begin
				entry_d = item;
			end else begin
				entry_d = prev_entry;
			end
		end else if (ctl.remove) begin
			entry_d = next_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end
endmodule

@@ tb/tb_bounded_priority_queue.sv @@
// Self-checking testbench for bounded_priority_queue: directed and random requests,
// each result compared against a sorted-slot prediction kept alongside the block.
// Depends on bpq_pkg and the bounded_priority_queue RTL only.
module tb_bounded_priority_queue;
	timeunit 1ns;
	timeprecision 1ps;
	import bpq_pkg::*;

	typedef struct packed {
		logic signed [DATA_W-1:0] head_value;
		logic signed [DATA_W-1:0] head_priority;
		logic [OUT_CNT_W-1:0]     entry_count;
		logic                     is_empty;
		logic                     is_full;
		logic                     refused;
	} head_report_t;

	localparam logic [1:0] OP_SPARE    = 2'd3;
	localparam int         IDLE_PCT    = 29;
	localparam int         HOLD_CYCLES = 300;
	localparam int         CYCLE_LIMIT = 200000;
	localparam int         PHASE_ITEMS = 130;
	localparam int         MAX_PRINTS  = 50;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CAP_W-1:0]         cfg_data = '0;
	logic                     req_valid = 1'b0;
	logic                     req_stall;
	logic [1:0]               opcode = OP_QUERY;
	logic signed [DATA_W-1:0] item_value = '0;
	logic signed [DATA_W-1:0] item_priority = '0;
	logic                     rsp_valid;
	logic                     rsp_stall = 1'b0;
	logic signed [DATA_W-1:0] head_value;
	logic signed [DATA_W-1:0] head_priority;
	logic [OUT_CNT_W-1:0]     entry_count;
	logic                     is_empty;
	logic                     is_full;
	logic                     refused;

	entry_t           slots [DEPTH];
	int               slot_count = 0;
	logic [CAP_W-1:0] capacity_setting = CAP_RESET;
	head_report_t     predicted_heads [$];

	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int cycle_count = 0;
	int mismatches = 0;
	int n_requests = 0;
	int n_inserts = 0;
	int n_removes = 0;
	int n_refused = 0;
	int n_full = 0;
	int n_cfg = 0;

	bounded_priority_queue u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.opcode       (opcode),
		.item_value   (item_value),
		.item_priority(item_priority),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.head_value   (head_value),
		.head_priority(head_priority),
		.entry_count  (entry_count),
		.is_empty     (is_empty),
		.is_full      (is_full),
		.refused      (refused)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending",
				cycle_count, predicted_heads.size());
			$display("tb_bounded_priority_queue: FAIL");
			$finish;
		end
	end

	// receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_left == 0 && hold_served != hold_requests) begin
			hold_left   <= HOLD_CYCLES;
			hold_served <= hold_requests;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		rsp_stall <= (hold_left != 0) || (rx_idle_on && $urandom_range(99) < IDLE_PCT);
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < MAX_PRINTS)
			$display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_results
		head_report_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (predicted_heads.size() == 0) begin
				report_mismatch("result with no request pending", head_value, 0);
			end else begin
				want = predicted_heads.pop_front();
				if (head_value !== want.head_value)
					report_mismatch("head_value", head_value, want.head_value);
				if (head_priority !== want.head_priority)
					report_mismatch("head_priority", head_priority, want.head_priority);
				if (entry_count !== want.entry_count)
					report_mismatch("entry_count", entry_count, want.entry_count);
				if (is_empty !== want.is_empty)
					report_mismatch("is_empty", is_empty, want.is_empty);
				if (is_full !== want.is_full)
					report_mismatch("is_full", is_full, want.is_full);
				if (refused !== want.refused)
					report_mismatch("refused", refused, want.refused);
			end
		end
	end

	// advance the sorted slots by one request and give the head report
	task automatic apply_request(input logic [1:0] op, input logic signed [DATA_W-1:0] val,
			input logic signed [DATA_W-1:0] pri, output head_report_t rsp);
		int pos;
		int i;
		int eff_cap;
		eff_cap = (int'(capacity_setting) > DEPTH) ? DEPTH : int'(capacity_setting);
		rsp = '0;
		if (op == OP_INSERT) begin
			if (slot_count >= eff_cap) begin
				rsp.refused = 1'b1;
			end else begin
				pos = 0;
				while (pos < slot_count && $signed(pri) <= $signed(slots[pos].pri))
					pos++;
				for (i = slot_count; i > pos; i--)
					slots[i] = slots[i - 1];
				slots[pos].val = val;
				slots[pos].pri = pri;
				slot_count++;
			end
		end else if (op == OP_REMOVE && slot_count > 0) begin
			for (i = 0; i + 1 < slot_count; i++)
				slots[i] = slots[i + 1];
			slot_count--;
		end
		if (slot_count > 0) begin
			rsp.head_value    = slots[0].val;
			rsp.head_priority = slots[0].pri;
		end
		rsp.entry_count = OUT_CNT_W'(slot_count);
		rsp.is_empty    = (slot_count == 0);
		rsp.is_full     = (slot_count >= eff_cap);
	endtask

	task automatic send_request(input logic [1:0] op, input logic signed [DATA_W-1:0] val,
			input logic signed [DATA_W-1:0] pri);
		head_report_t rsp;
		if (tx_idle_on) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_valid     <= 1'b1;
		opcode        <= op;
		item_value    <= val;
		item_priority <= pri;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		apply_request(op, val, pri, rsp);
		predicted_heads.push_back(rsp);
		n_requests++;
		if (op == OP_INSERT && !rsp.refused)
			n_inserts++;
		if (op == OP_REMOVE)
			n_removes++;
		if (rsp.refused)
			n_refused++;
		if (rsp.is_full)
			n_full++;
	endtask

	// drop the request line, drain, then write capacity
	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		req_valid <= 1'b0;
		while (predicted_heads.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		capacity_setting = cap;
		n_cfg++;
	endtask

	function automatic logic signed [DATA_W-1:0] random_priority();
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3, 4, 5: return $urandom_range(7) - 4;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random_request(input int insert_pct, input int remove_pct);
		int pick;
		logic [1:0] op;
		pick = $urandom_range(99);
		if (pick < insert_pct)
			op = OP_INSERT;
		else if (pick < insert_pct + remove_pct)
			op = OP_REMOVE;
		else
			op = $urandom_range(1) ? OP_QUERY : OP_SPARE;
		send_request(op, $urandom, random_priority());
	endtask

	task automatic test_empty_queue();
		send_request(OP_QUERY, $urandom, $urandom);
		send_request(OP_REMOVE, $urandom, $urandom);
		send_request(OP_SPARE, $urandom, $urandom);
	endtask

	task automatic test_priority_order();
		send_request(OP_INSERT, 32'sh7fffffff, 32'sd0);
		send_request(OP_INSERT, 32'sh80000000, 32'sh7fffffff);
		send_request(OP_INSERT, 32'sd1, 32'sh80000000);
		send_request(OP_INSERT, 32'sd2, 32'sd0);
		send_request(OP_INSERT, -32'sd1, 32'sh7fffffff);
		repeat (6)
			send_request(OP_REMOVE, $urandom, $urandom);
	endtask

	task automatic test_capacity_limits();
		write_capacity(CAP_W'(1));
		send_request(OP_INSERT, 32'sd10, 32'sd5);
		send_request(OP_INSERT, 32'sd11, 32'sd9);
		write_capacity(CAP_W'(0));
		send_request(OP_QUERY, $urandom, $urandom);
		send_request(OP_INSERT, 32'sd12, 32'sd1);
		send_request(OP_REMOVE, $urandom, $urandom);
		send_request(OP_INSERT, 32'sd13, 32'sd1);
		write_capacity(CAP_W'(31));
	endtask

	task automatic test_random_capacities();
		logic [CAP_W-1:0] caps [8];
		int p;
		int k;
		caps = '{CAP_W'(16), CAP_W'(31), CAP_W'(1), CAP_W'(5), CAP_W'(0), CAP_W'(17),
			CAP_W'(2), CAP_W'($urandom_range(31))};
		for (p = 0; p < 8; p++) begin
			write_capacity(caps[p]);
			for (k = 0; k < PHASE_ITEMS; k++)
				send_random_request(k < PHASE_ITEMS / 2 ? 60 : 25, k < PHASE_ITEMS / 2 ? 25 : 55);
		end
	endtask

	task automatic test_back_pressure();
		int k;
		write_capacity(CAP_W'(16));
		tx_idle_on = 1'b0;
		hold_requests <= hold_requests + 1;
		for (k = 0; k < 40; k++)
			send_random_request(70, 20);
		tx_idle_on = 1'b1;
	endtask

	task automatic test_no_idle_stretch();
		int k;
		write_capacity(CAP_W'(12));
		tx_idle_on = 1'b0;
		rx_idle_on <= 1'b0;
		for (k = 0; k < 150; k++)
			send_random_request(k < 75 ? 55 : 30, k < 75 ? 30 : 50);
		tx_idle_on = 1'b1;
		rx_idle_on <= 1'b1;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_queue();
		test_priority_order();
		test_capacity_limits();
		test_random_capacities();
		test_back_pressure();
		test_no_idle_stretch();
		req_valid <= 1'b0;
		while (predicted_heads.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		$display("ran %0d requests over %0d capacity writes: %0d stored, %0d removes,",
			n_requests, n_cfg, n_inserts, n_removes);
		$display("%0d refused inserts, %0d results full, one %0d-cycle receiver hold-off",
			n_refused, n_full, HOLD_CYCLES);
		if (mismatches == 0)
			$display("tb_bounded_priority_queue: PASS");
		else
			$display("tb_bounded_priority_queue: FAIL");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+sv
sv/bpq_pkg.sv
sv/bpq_cell.sv
sv/bounded_priority_queue.sv
tb/tb_bounded_priority_queue.sv
